// ===== rtl/hmw_pkg.sv =====
// ----------------------------------------------------------------------------
// hmw_pkg
// Shared constants and types for the binary hit-or-miss window block.
// ----------------------------------------------------------------------------
package hmw_pkg;

  localparam int MAX_WINDOW = 7;
  localparam int MAX_LINE   = 1024;

  localparam int WIN_BITS  = MAX_WINDOW * MAX_WINDOW;
  localparam int HIST_W    = MAX_WINDOW - 1;
  localparam int SIZE_W    = 3;
  localparam int COL_W     = $clog2(MAX_LINE);
  localparam int WIDTH_W   = 11;
  localparam int ROW_W     = 16;
  localparam int PIXEL_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 49;

  localparam logic [PIXEL_W-1:0] MATCH_VALUE = 8'd255;
  localparam logic [PIXEL_W-1:0] MISS_VALUE  = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE  = 3'd0,
    CFG_CARE_MASK    = 3'd1,
    CFG_VALUE_MASK   = 3'd2,
    CFG_IMAGE_WIDTH  = 3'd3,
    CFG_IMAGE_HEIGHT = 3'd4
  } cfg_reg_t;

endpackage

// ===== rtl/hmw_ram.sv =====
// ----------------------------------------------------------------------------
// hmw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/hmw_match.sv =====
// ----------------------------------------------------------------------------
// hmw_match
// Masked template compare of the binary window for every window size,
// then selection by the active size.
// ----------------------------------------------------------------------------
module hmw_match (
  input  logic [hmw_pkg::WIN_BITS-1:0]   win,
  input  logic [hmw_pkg::CFG_DATA_W-1:0] care,
  input  logic [hmw_pkg::CFG_DATA_W-1:0] value,
  input  logic [hmw_pkg::SIZE_W-1:0]     size,
  output logic                           hit
);

  logic [hmw_pkg::MAX_WINDOW:1] hit_by_size;

  // window bit for template (y, x) sits at column age s-1-x, line age s-1-y
  always_comb begin
    for (int s = 1; s <= hmw_pkg::MAX_WINDOW; s++) begin
      hit_by_size[s] = 1'b1;
      for (int y = 0; y < s; y++) begin
        for (int x = 0; x < s; x++) begin
          if (care[y*s+x] &&
              (win[(s-1-x)*hmw_pkg::MAX_WINDOW + (s-1-y)] != value[y*s+x])) begin
            hit_by_size[s] = 1'b0;
          end
        end
      end
    end
  end

  assign hit = hit_by_size[size];

endmodule

// ===== rtl/binary_hit_or_miss_window.sv =====
// ----------------------------------------------------------------------------
// binary_hit_or_miss_window
// Pipeline: an accepted pixel's position and line memory read are registered
//   into stage 1; the compare result enters the output register when stage 1 fires.
// Throughput: one pixel per cycle; the input stalls only while a result waits.
// Reset: synchronous, clears counters, window, pipeline valids and config;
//   the line memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module binary_hit_or_miss_window (
  input  logic                           clk,
  input  logic                           rst_n,
  // pixel stream
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hmw_pkg::PIXEL_W-1:0]    in_pixel,
  input  logic                           in_frame_start,
  // window results
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hmw_pkg::PIXEL_W-1:0]    out_match_value,
  output logic [hmw_pkg::ROW_W-1:0]      out_centre_row,
  output logic [hmw_pkg::COL_W-1:0]      out_centre_col,
  output logic                           out_last,
  // configuration
  input  logic                           cfg_we,
  input  logic [hmw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hmw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = hmw_pkg::COL_W;
  localparam int RW = hmw_pkg::ROW_W;
  localparam int WW = hmw_pkg::WIDTH_W;
  localparam int SW = hmw_pkg::SIZE_W;
  localparam int HW = hmw_pkg::HIST_W;
  localparam int MW = hmw_pkg::MAX_WINDOW;

  // configuration registers
  logic [SW-1:0]                  window_size_r;
  logic [hmw_pkg::CFG_DATA_W-1:0] care_mask_r;
  logic [hmw_pkg::CFG_DATA_W-1:0] value_mask_r;
  logic [WW-1:0]                  image_width_r;
  logic [RW-1:0]                  image_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r  <= SW'(3);
      care_mask_r    <= '0;
      value_mask_r   <= '0;
      image_width_r  <= WW'(hmw_pkg::MAX_LINE);
      image_height_r <= RW'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        hmw_pkg::CFG_WINDOW_SIZE:  window_size_r  <= cfg_wdata[SW-1:0];
        hmw_pkg::CFG_CARE_MASK:    care_mask_r    <= cfg_wdata;
        hmw_pkg::CFG_VALUE_MASK:   value_mask_r   <= cfg_wdata;
        hmw_pkg::CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WW-1:0];
        hmw_pkg::CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [SW-1:0] n_eff;
  logic [WW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [SW-1:0] centre_off;

  always_comb begin
    n_eff = (window_size_r == '0) ? SW'(1) : window_size_r;
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (image_width_r > WW'(hmw_pkg::MAX_LINE)) begin
      w_eff = WW'(hmw_pkg::MAX_LINE);
    end else begin
      w_eff = image_width_r;
    end
    h_eff = (image_height_r == '0) ? RW'(1) : image_height_r;
    // distance from the bottom-right corner back to the window centre
    centre_off = n_eff - SW'(1) - (n_eff >> 1);
  end

  // ---------------------------------------------------------------------------
  // stage 0: position of the incoming pixel, line memory read
  // ---------------------------------------------------------------------------
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [CW-1:0] c0;
  logic [RW-1:0] r0;
  logic [RW:0]   row_tmp;
  logic [WW-1:0] col_inc;
  logic [RW:0]   row_inc;

  logic          s1_v_r;
  logic          s1_fire;
  logic          in_acc;

  always_comb begin
    row_tmp = '0;
    if (in_frame_start) begin
      c0 = '0;
      r0 = '0;
    end else begin
      if ({1'b0, col_cnt_r} >= w_eff) begin
        c0      = '0;
        row_tmp = {1'b0, row_cnt_r} + (RW+1)'(1);
      end else begin
        c0      = col_cnt_r;
        row_tmp = {1'b0, row_cnt_r};
      end
      r0 = (row_tmp >= {1'b0, h_eff}) ? '0 : row_tmp[RW-1:0];
    end

    col_inc = {1'b0, c0} + WW'(1);
    row_inc = {1'b0, r0} + (RW+1)'(1);
    if (col_inc >= w_eff) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
    end else begin
      col_cnt_nxt = col_inc[CW-1:0];
      row_cnt_nxt = r0;
    end
  end

  assign in_ready = !s1_v_r || s1_fire;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_acc) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: column history, window shift, template compare
  // ---------------------------------------------------------------------------
  logic [CW-1:0]               s1_c_r;
  logic [RW-1:0]               s1_r_r;
  logic                        s1_bit_r;
  logic                        fwd_r;
  logic [HW-1:0]               hist_wr_r;
  logic [HW-1:0]               ram_rdata;
  logic [HW-1:0]               hist;
  logic [HW-1:0]               hist_new;
  logic [MW-1:0]               col_bits;
  logic [hmw_pkg::WIN_BITS-1:0] window_r, window_nxt;
  logic                        hit;
  logic                        produce;
  logic                        out_valid_r;

  // a transaction taken while stage 1 writes the same column reads stale data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else if (in_acc) begin
      s1_v_r <= 1'b1;
      fwd_r  <= s1_fire && (s1_c_r == c0);
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_c_r   <= c0;
      s1_r_r   <= r0;
      s1_bit_r <= |in_pixel;
    end
    if (s1_fire) begin
      hist_wr_r <= hist_new;
    end
  end

  hmw_ram #(
    .WIDTH (HW),
    .DEPTH (hmw_pkg::MAX_LINE)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_c_r),
    .wdata (hist_new),
    .re    (in_acc),
    .raddr (c0),
    .rdata (ram_rdata)
  );

  assign s1_fire    = s1_v_r && (!out_valid_r || out_ready);
  assign hist       = fwd_r ? hist_wr_r : ram_rdata;
  assign col_bits   = {hist, s1_bit_r};
  assign hist_new   = {hist[HW-2:0], s1_bit_r};
  assign window_nxt = {window_r[hmw_pkg::WIN_BITS-MW-1:0], col_bits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
    end else if (s1_fire) begin
      window_r <= window_nxt;
    end
  end

  hmw_match u_match (
    .win   (window_nxt),
    .care  (care_mask_r),
    .value (value_mask_r),
    .size  (n_eff),
    .hit   (hit)
  );

  // full window once both the column and the row reach n-1
  assign produce = ({1'b0, s1_c_r} + WW'(1) >= WW'(n_eff)) &&
                   ({1'b0, s1_r_r} + (RW+1)'(1) >= (RW+1)'(n_eff));

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic [hmw_pkg::PIXEL_W-1:0] match_value_r;
  logic [RW-1:0]               centre_row_r;
  logic [CW-1:0]               centre_col_r;
  logic                        last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= produce;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && produce) begin
      match_value_r <= hit ? hmw_pkg::MATCH_VALUE : hmw_pkg::MISS_VALUE;
      centre_row_r  <= s1_r_r - RW'(centre_off);
      centre_col_r  <= s1_c_r - CW'(centre_off);
      last_r        <= (s1_r_r == h_eff - RW'(1)) && ({1'b0, s1_c_r} == w_eff - WW'(1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_value = match_value_r;
  assign out_centre_row  = centre_row_r;
  assign out_centre_col  = centre_col_r;
  assign out_last        = last_r;

endmodule

// ===== rtl/hmw_checker.sv =====
// ----------------------------------------------------------------------------
// hmw_checker
// Port-level checks on the binary hit-or-miss window, bound to the top level.
// ----------------------------------------------------------------------------
module hmw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hmw_pkg::PIXEL_W-1:0] out_match_value,
  input logic [hmw_pkg::ROW_W-1:0]   out_centre_row,
  input logic [hmw_pkg::COL_W-1:0]   out_centre_col,
  input logic                        out_last
);

  // a stalled result transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_value) &&
      $stable(out_centre_row) && $stable(out_centre_col) && $stable(out_last))
    else $error("result changed while stalled");

  a_binary_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_value == hmw_pkg::MATCH_VALUE) ||
                  (out_match_value == hmw_pkg::MISS_VALUE))
    else $error("match value not binary");

  // with the output register empty the pipeline never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_hit_or_miss_window hmw_checker u_hmw_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for binary_hit_or_miss_window: a scoreboard predicts
// every window result from the accepted pixels and the programmed registers,
// while random sender idling and receiver stalls exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;

  localparam int PIXEL_W    = hmw_pkg::PIXEL_W;
  localparam int ROW_W      = hmw_pkg::ROW_W;
  localparam int COL_W      = hmw_pkg::COL_W;
  localparam int SIZE_W     = hmw_pkg::SIZE_W;
  localparam int WIDTH_W    = hmw_pkg::WIDTH_W;
  localparam int HIST_W     = hmw_pkg::HIST_W;
  localparam int WIN_BITS   = hmw_pkg::WIN_BITS;
  localparam int MAX_WINDOW = hmw_pkg::MAX_WINDOW;
  localparam int MAX_LINE   = hmw_pkg::MAX_LINE;
  localparam int CFG_IDX_W  = hmw_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = hmw_pkg::CFG_DATA_W;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 300;
  localparam int PAUSE_PHASE   = 2;
  localparam int HOLD_PHASE    = 5;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic [PIXEL_W-1:0] match_value;
    logic [ROW_W-1:0]   centre_row;
    logic [COL_W-1:0]   centre_col;
    logic               last;
  } hmw_result_t;

  class hmw_scoreboard;
    logic [SIZE_W-1:0]     win_size;
    logic [WIN_BITS-1:0]   care;
    logic [WIN_BITS-1:0]   want;
    logic [WIDTH_W-1:0]    width_raw;
    logic [ROW_W-1:0]      height_raw;
    bit   [HIST_W-1:0]     line_hist [MAX_LINE];
    bit   [WIN_BITS-1:0]   window;
    int unsigned           col_pos;
    int unsigned           row_pos;
    hmw_result_t           expected_q[$];
    int unsigned           errors;

    function new();
      win_size   = 3'd3;
      care       = '0;
      want       = '0;
      width_raw  = 11'd1024;
      height_raw = 16'd1024;
      window     = '0;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
      foreach (line_hist[i]) line_hist[i] = '0;
    endfunction

    static function int unsigned line_width(logic [WIDTH_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_LINE) return MAX_LINE;
      return raw;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        hmw_pkg::CFG_WINDOW_SIZE:  win_size   = data[SIZE_W-1:0];
        hmw_pkg::CFG_CARE_MASK:    care       = data[WIN_BITS-1:0];
        hmw_pkg::CFG_VALUE_MASK:   want       = data[WIN_BITS-1:0];
        hmw_pkg::CFG_IMAGE_WIDTH:  width_raw  = data[WIDTH_W-1:0];
        hmw_pkg::CFG_IMAGE_HEIGHT: height_raw = data[ROW_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [PIXEL_W-1:0] pix, logic fs);
      int unsigned n, w, h, c, r, t, d, e;
      bit b, ok;
      bit [HIST_W-1:0] hist;
      hmw_result_t res;
      n = (win_size == 0) ? 1 : ((win_size > MAX_WINDOW) ? MAX_WINDOW : win_size);
      w = line_width(width_raw);
      h = (height_raw == 0) ? 1 : height_raw;
      c = col_pos;
      r = row_pos;
      b = (pix != 0);
      if (fs) begin
        c = 0;
        r = 0;
      end else begin
        // stale position after a geometry change
        if (c >= w) begin
          c = 0;
          r++;
        end
        if (r >= h) r = 0;
      end
      hist = line_hist[c];
      window = {window[WIN_BITS-MAX_WINDOW-1:0], hist, b};
      line_hist[c] = {hist[HIST_W-2:0], b};
      if (c + 1 >= n && r + 1 >= n) begin
        ok = 1'b1;
        for (int y = 0; y < n; y++) begin
          for (int x = 0; x < n; x++) begin
            t = y * n + x;
            d = n - 1 - y;
            e = n - 1 - x;
            if (care[t] && (window[e * MAX_WINDOW + d] != want[t])) ok = 1'b0;
          end
        end
        res.match_value = ok ? hmw_pkg::MATCH_VALUE : hmw_pkg::MISS_VALUE;
        res.centre_row  = ROW_W'(r - (n - 1) + n / 2);
        res.centre_col  = COL_W'(c - (n - 1) + n / 2);
        res.last        = (r == h - 1) && (c == w - 1);
        expected_q.push_back(res);
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r & 16'hFFFF;
    endfunction

    function void check_result(hmw_result_t got);
      hmw_result_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: value %0d row %0d col %0d last %0d",
                   got.match_value, got.centre_row, got.centre_col, got.last);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.match_value !== exp_res.match_value || got.centre_row !== exp_res.centre_row ||
          got.centre_col !== exp_res.centre_col || got.last !== exp_res.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected value %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
                   exp_res.match_value, exp_res.centre_row, exp_res.centre_col, exp_res.last,
                   got.match_value, got.centre_row, got.centre_col, got.last);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIXEL_W-1:0]    in_pixel;
  logic                  in_frame_start;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIXEL_W-1:0]    out_match_value;
  logic [ROW_W-1:0]      out_centre_row;
  logic [COL_W-1:0]      out_centre_col;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hmw_scoreboard sb = new();

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_left    = 0;
  int cycle_count  = 0;
  int random_items = 0;

  binary_hit_or_miss_window i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pixel        (in_pixel),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_value (out_match_value),
    .out_centre_row  (out_centre_row),
    .out_centre_col  (out_centre_col),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_pixel       = '0;
    in_frame_start = 1'b0;
    out_ready      = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = hmw_pkg::CFG_WINDOW_SIZE;
    cfg_wdata      = '0;
  end

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("binary_hit_or_miss_window verification failed");
      $finish;
    end
  end

  // receiver: long hold-off when requested, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_match_value, out_centre_row, out_centre_col, out_last});
  end

  function automatic logic [CFG_DATA_W-1:0] rand49();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[CFG_DATA_W-1:0];
  endfunction

  function automatic logic [PIXEL_W-1:0] draw_pixel(int mode);
    case (mode)
      1: return ($urandom_range(0, 9) == 0) ? '0 : PIXEL_W'($urandom_range(1, 255));
      2: return ($urandom_range(0, 9) != 0) ? '0 : PIXEL_W'($urandom_range(1, 255));
      default: return PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // one pixel transaction; valid stays high until the next call or stop_input
  task automatic send_pixel(logic [PIXEL_W-1:0] pix, logic fs);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    sb.note_input(pix, fs);
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int k);
    logic [CFG_DATA_W-1:0] d_size, d_care, d_val, d_w, d_h;
    int unsigned old_w, new_w, items, fg;
    bit keep;
    logic fs;
    case (k % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 49; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 49; end
      default: begin idle_pct = 12; stall_pct = 12; end
    endcase
    case ($urandom_range(0, 9))
      0: d_size = '0;
      1: d_size = CFG_DATA_W'(MAX_WINDOW);
      default: d_size = CFG_DATA_W'($urandom_range(1, 5));
    endcase
    // result per pixel so the hold-off backs up the pipeline
    if (k == HOLD_PHASE) d_size = CFG_DATA_W'(1);
    d_w = ($urandom_range(0, 7) == 0) ? CFG_DATA_W'($urandom_range(15, 40)) :
                                        CFG_DATA_W'($urandom_range(0, 14));
    case ($urandom_range(0, 9))
      0: d_h = '0;
      1: d_h = CFG_DATA_W'(16'hFFFF);
      default: d_h = CFG_DATA_W'($urandom_range(1, 9));
    endcase
    case ($urandom_range(0, 3))
      0: d_care = '0;
      1: d_care = '1;
      2: d_care = rand49() & rand49() & rand49();
      default: d_care = rand49();
    endcase
    case ($urandom_range(0, 2))
      0: d_val = '0;
      1: d_val = '1;
      default: d_val = rand49();
    endcase
    // junk above the register width
    if ($urandom_range(0, 3) == 0) d_size = d_size | (rand49() << SIZE_W);
    if ($urandom_range(0, 3) == 0) d_w = d_w | (rand49() << WIDTH_W);
    if ($urandom_range(0, 3) == 0) d_h = d_h | (rand49() << ROW_W);
    // keeping the position is only safe when the line does not get longer
    old_w = hmw_scoreboard::line_width(sb.width_raw);
    new_w = hmw_scoreboard::line_width(d_w[WIDTH_W-1:0]);
    keep  = (new_w <= old_w) && ($urandom_range(0, 1) == 1);
    write_reg(hmw_pkg::CFG_WINDOW_SIZE, d_size);
    write_reg(hmw_pkg::CFG_CARE_MASK, d_care);
    write_reg(hmw_pkg::CFG_VALUE_MASK, d_val);
    write_reg(hmw_pkg::CFG_IMAGE_WIDTH, d_w);
    write_reg(hmw_pkg::CFG_IMAGE_HEIGHT, d_h);
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'(hmw_pkg::CFG_IMAGE_HEIGHT + $urandom_range(1, 3)), rand49());
    items = $urandom_range(20, 80);
    fg    = $urandom_range(0, 2);
    for (int i = 0; i < items; i++) begin
      if (k == PAUSE_PHASE && i == items / 2) begin
        stop_input();
        wait_drained();
      end
      if (k == HOLD_PHASE && i == 3) hold_left = HOLD_CYCLES;
      fs = (i == 0) ? !keep : ($urandom_range(0, 49) == 0);
      send_pixel(draw_pixel(fg), fs);
      random_items++;
    end
    stop_input();
    wait_drained();
  endtask

  initial begin
    int k;
    logic [PIXEL_W-1:0] seq_a [17] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd0, 8'd255, 8'd0, 8'd2,
                                       8'd255, 8'd0, 8'd64, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0,
                                       8'd7};
    logic [PIXEL_W-1:0] seq_b [6] = '{8'd0, 8'd1, 8'd255, 8'd128, 8'd2, 8'd0};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // 3x3 on a 4x3 image, don't-care centre, mask bits beyond the window set
    write_reg(hmw_pkg::CFG_WINDOW_SIZE, CFG_DATA_W'(3));
    write_reg(hmw_pkg::CFG_CARE_MASK, {40'hFF_FFFF_FFFF, 9'b111_101_111});
    write_reg(hmw_pkg::CFG_VALUE_MASK, {40'hA5_5A5A_A5A5, 9'b101_000_101});
    write_reg(hmw_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(4));
    write_reg(hmw_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    foreach (seq_a[i]) send_pixel(seq_a[i], (i == 0) || (i == 16));
    stop_input();
    wait_drained();

    // zero size, width and height fall back to one
    write_reg(hmw_pkg::CFG_WINDOW_SIZE, '0);
    write_reg(hmw_pkg::CFG_CARE_MASK, '1);
    write_reg(hmw_pkg::CFG_VALUE_MASK, '1);
    write_reg(hmw_pkg::CFG_IMAGE_WIDTH, '0);
    write_reg(hmw_pkg::CFG_IMAGE_HEIGHT, '0);
    foreach (seq_b[i]) send_pixel(seq_b[i], i[0]);
    stop_input();
    wait_drained();

    // widest line: width clamps to the line memory, tallest image
    idle_pct  = 12;
    stall_pct = 12;
    write_reg(hmw_pkg::CFG_WINDOW_SIZE, CFG_DATA_W'(1));
    write_reg(hmw_pkg::CFG_VALUE_MASK, rand49());
    write_reg(hmw_pkg::CFG_IMAGE_WIDTH, CFG_DATA_W'(11'h7FF));
    write_reg(hmw_pkg::CFG_IMAGE_HEIGHT, CFG_DATA_W'(16'hFFFF));
    for (int i = 0; i < MAX_LINE + 6; i++) send_pixel(draw_pixel(0), i == 0);
    stop_input();
    wait_drained();

    // run past the hold-off phase even when the item budget is spent early
    k = 0;
    while ((random_items < RANDOM_ITEMS) || (k <= HOLD_PHASE)) begin
      random_phase(k);
      k++;
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("binary_hit_or_miss_window verification clean");
    end else begin
      $display("binary_hit_or_miss_window verification failed");
    end
    $finish;
  end

endmodule

// ===== binary_hit_or_miss_window.f =====
rtl/hmw_pkg.sv
rtl/hmw_ram.sv
rtl/hmw_match.sv
rtl/binary_hit_or_miss_window.sv
rtl/hmw_checker.sv
test/tb.sv
